// ===== hw/rtl/triangle_tangent_bitangent_assert.svh =====
// Assertion macros for the triangle tangent/bitangent block.
// Included by files that carry concurrent assertions; no other dependency.
`ifndef TRIANGLE_TANGENT_BITANGENT_ASSERT_SVH
`define TRIANGLE_TANGENT_BITANGENT_ASSERT_SVH
`ifndef SYNTHESIS
`define TBT_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tbt assertion failed");
`define TBT_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tbt assertion failed");
`else
`define TBT_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define TBT_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== hw/rtl/tbt_pkg.sv =====
// Shared constants, types and helpers for the tangent/bitangent block.
// No dependencies.
package tbt_pkg;
   localparam int FRAC_BITS = 16;
   localparam int DW        = 33;              // edge delta width
   localparam int PW        = DW - 1;          // delta magnitude width
   localparam int AW        = 2 * PW + 2;      // accumulator width
   localparam int DIV_N     = AW + FRAC_BITS;  // divider steps
   localparam int DCW       = $clog2(DIV_N);
   localparam int MCW       = $clog2(PW);
   localparam logic [1:0] LAST_PHASE = 2'd2;
   localparam logic [2:0] LAST_COMP  = 3'd5;
   localparam logic [2:0] NUM_AXES   = 3'd3;

   typedef enum logic [2:0] {
      S_IDLE, S_KICK, S_DMUL, S_NMUL, S_DIV, S_OUT
   } tbt_state_type;

   typedef struct packed {
      logic start;
      logic clear;
      logic neg;
   } tbt_mac_cmd_type;

   function automatic logic [PW-1:0] abs_delta(input logic signed [DW-1:0] d);
      logic [DW-1:0] t;
      t = d[DW-1] ? -d : d;
      return t[PW-1:0];
   endfunction
endpackage

// ===== hw/rtl/tbt_if.sv =====
// Vertex and result channel interfaces, valid/ready handshake.
// No dependencies.
interface tbt_vtx_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic signed [31:0] pos_z;
   logic signed [31:0] tex_u;
   logic signed [31:0] tex_v;
   modport source(output valid, pos_x, pos_y, pos_z, tex_u, tex_v, input ready);
   modport sink(input valid, pos_x, pos_y, pos_z, tex_u, tex_v, output ready);
endinterface

interface tbt_vec_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] tangent_x;
   logic signed [31:0] tangent_y;
   logic signed [31:0] tangent_z;
   logic signed [31:0] bitangent_x;
   logic signed [31:0] bitangent_y;
   logic signed [31:0] bitangent_z;
   logic               degenerate;
   modport source(output valid, tangent_x, tangent_y, tangent_z, bitangent_x,
                  bitangent_y, bitangent_z, degenerate, input ready);
   modport sink(input valid, tangent_x, tangent_y, tangent_z, bitangent_x,
                bitangent_y, bitangent_z, degenerate, output ready);
endinterface

// ===== hw/rtl/tbt_mac.sv =====
// Bit-serial signed multiply-accumulate, one multiplier bit per cycle.
// Depends on tbt_pkg.
module tbt_mac
   import tbt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  tbt_mac_cmd_type       cmd,
   input  logic signed [DW-1:0]  op_a,
   input  logic signed [DW-1:0]  op_b,
   output logic                  done,
   output logic signed [AW-1:0]  acc
);
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [MCW-1:0]       cnt_ff, cnt_in;
   logic [2*PW-1:0]      mc_ff;
   logic [PW-1:0]        mb_ff;
   logic                 sub_ff;
   logic signed [AW-1:0] acc_ff;
   logic signed [AW-1:0] addend;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (cmd.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == MCW'(PW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   assign addend = $signed({2'b00, mc_ff});

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         mc_ff  <= {{PW{1'b0}}, abs_delta(op_a)};
         mb_ff  <= abs_delta(op_b);
         sub_ff <= op_a[DW-1] ^ op_b[DW-1] ^ cmd.neg;
         if (cmd.clear) begin
            acc_ff <= '0;
         end
      end else if (busy_ff) begin
         if (mb_ff[0]) begin
            acc_ff <= sub_ff ? acc_ff - addend : acc_ff + addend;
         end
         mc_ff <= {mc_ff[2*PW-2:0], 1'b0};
         mb_ff <= {1'b0, mb_ff[PW-1:1]};
      end
   end

   assign done = done_ff;
   assign acc  = acc_ff;
endmodule

// ===== hw/rtl/tbt_div.sv =====
// Restoring bit-serial signed divider: num * 2^FRAC_BITS / den, truncated,
// saturated to 32 bits. One quotient bit per cycle. Depends on tbt_pkg.
module tbt_div
   import tbt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic signed [AW-1:0]  num,
   input  logic signed [AW-1:0]  den,
   output logic                  done,
   output logic signed [31:0]    quot
);
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DCW-1:0]   cnt_ff, cnt_in;
   logic [DIV_N-1:0] dvd_ff;
   logic [AW-1:0]    rem_ff;
   logic [AW-1:0]    dmag_ff;
   logic [31:0]      q_ff;
   logic             ovf_ff;
   logic             neg_ff;
   logic [AW-1:0]    nmag;
   logic [AW-1:0]    dmag;
   logic [AW:0]      trial;
   logic [AW:0]      diff;

   assign nmag  = num[AW-1] ? AW'(-num) : AW'(num);
   assign dmag  = den[AW-1] ? AW'(-den) : AW'(den);
   assign trial = {rem_ff, dvd_ff[DIV_N-1]};
   assign diff  = trial - {1'b0, dmag_ff};

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DCW'(DIV_N - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         dvd_ff  <= {nmag, {FRAC_BITS{1'b0}}};
         rem_ff  <= '0;
         dmag_ff <= dmag;
         q_ff    <= '0;
         ovf_ff  <= 1'b0;
         neg_ff  <= num[AW-1] ^ den[AW-1];
      end else if (busy_ff) begin
         dvd_ff <= {dvd_ff[DIV_N-2:0], 1'b0};
         rem_ff <= diff[AW] ? trial[AW-1:0] : diff[AW-1:0];
         q_ff   <= {q_ff[30:0], ~diff[AW]};
         ovf_ff <= ovf_ff | q_ff[31];
      end
   end

   always_comb begin
      if (!neg_ff) begin
         quot = (ovf_ff || q_ff[31]) ? 32'sh7FFF_FFFF : $signed(q_ff);
      end else begin
         quot = (ovf_ff || (q_ff[31] && q_ff[30:0] != '0)) ?
                32'sh8000_0000 : $signed(-q_ff);
      end
   end

   assign done = done_ff;
endmodule

// ===== hw/rtl/triangle_tangent_bitangent.sv =====
// Top level: per-triangle tangent and bitangent from a vertex stream.
// Depends on tbt_pkg, tbt_if, tbt_mac, tbt_div and the assertion header.
//
//   channel   dir  beat
//   req_chan  in   one vertex: pos_x/y/z, tex_u/v, Q16.16
//   rsp_chan  out  tangent_x/y/z, bitangent_x/y/z, degenerate
//
// The first two vertices of a triangle are stored. The third starts the
// computation on the shared bit-serial multiplier and divider (one bit a cycle).
// Synchronous active-high reset clears the vertex phase and the sequencer.
// A finished result waits in the output register; a new vertex is taken
// while it waits, only the next result stalls on rsp_chan.ready.
`include "triangle_tangent_bitangent_assert.svh"
module triangle_tangent_bitangent
   import tbt_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   tbt_vtx_if.sink   req_chan,
   tbt_vec_if.source rsp_chan
);
   tbt_state_type        state_ff, state_in;
   logic [1:0]           phase_ff, phase_in;
   logic                 sel_ff, sel_in;
   logic [2:0]           comp_ff, comp_in;
   logic                 degen_ff, degen_in;
   logic                 rsp_valid_ff;
   logic                 req_acc;
   logic                 out_load, det_we, res_we, div_start;
   tbt_mac_cmd_type      mac_cmd;
   logic signed [DW-1:0] mac_a, mac_b;
   logic                 mac_done, div_done;
   logic signed [AW-1:0] mac_acc;
   logic signed [31:0]   div_quot;
   logic signed [AW-1:0] det_ff;
   logic [31:0]          hp_ff [6];
   logic [31:0]          ht_ff [4];
   logic signed [DW-1:0] dp1_ff [3];
   logic signed [DW-1:0] dp2_ff [3];
   logic signed [DW-1:0] du1_ff, dv1_ff, du2_ff, dv2_ff;
   logic signed [31:0]   res_ff [6];
   logic signed [31:0]   out_ff [6];
   logic                 out_degen_ff;
   logic [2:0]           axis_sel;

   assign req_acc        = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == S_IDLE);

   always_comb begin
      state_in  = state_ff;
      phase_in  = phase_ff;
      sel_in    = sel_ff;
      comp_in   = comp_ff;
      degen_in  = degen_ff;
      mac_cmd   = '0;
      div_start = 1'b0;
      det_we    = 1'b0;
      res_we    = 1'b0;
      out_load  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               if (phase_ff == LAST_PHASE) begin
                  phase_in = '0;
                  state_in = S_KICK;
               end else begin
                  phase_in = phase_ff + 1'b1;
               end
            end
         end
         S_KICK: begin
            mac_cmd  = '{start: 1'b1, clear: 1'b1, neg: 1'b0};
            sel_in   = 1'b0;
            state_in = S_DMUL;
         end
         S_DMUL: begin
            if (mac_done) begin
               if (!sel_ff) begin
                  mac_cmd = '{start: 1'b1, clear: 1'b0, neg: 1'b1};
                  sel_in  = 1'b1;
               end else begin
                  det_we = 1'b1;
                  if (mac_acc == '0) begin
                     degen_in = 1'b1;
                     state_in = S_OUT;
                  end else begin
                     degen_in = 1'b0;
                     comp_in  = '0;
                     sel_in   = 1'b0;
                     mac_cmd  = '{start: 1'b1, clear: 1'b1, neg: 1'b0};
                     state_in = S_NMUL;
                  end
               end
            end
         end
         S_NMUL: begin
            if (mac_done) begin
               if (!sel_ff) begin
                  mac_cmd = '{start: 1'b1, clear: 1'b0, neg: 1'b1};
                  sel_in  = 1'b1;
               end else begin
                  div_start = 1'b1;
                  state_in  = S_DIV;
               end
            end
         end
         S_DIV: begin
            if (div_done) begin
               res_we = 1'b1;
               if (comp_ff == LAST_COMP) begin
                  state_in = S_OUT;
               end else begin
                  comp_in  = comp_ff + 1'b1;
                  sel_in   = 1'b0;
                  mac_cmd  = '{start: 1'b1, clear: 1'b1, neg: 1'b0};
                  state_in = S_NMUL;
               end
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               out_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= '0;
         sel_ff       <= 1'b0;
         comp_ff      <= '0;
         degen_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         sel_ff   <= sel_in;
         comp_ff  <= comp_in;
         degen_ff <= degen_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // operand select for the product being started
   assign axis_sel = (comp_in >= NUM_AXES) ? comp_in - NUM_AXES : comp_in;

   always_comb begin
      if (state_in == S_DMUL) begin
         mac_a = sel_in ? dv1_ff : du1_ff;
         mac_b = sel_in ? du2_ff : dv2_ff;
      end else if (comp_in < NUM_AXES) begin
         mac_a = sel_in ? dp2_ff[axis_sel[1:0]] : dp1_ff[axis_sel[1:0]];
         mac_b = sel_in ? dv1_ff : dv2_ff;
      end else begin
         mac_a = sel_in ? dp1_ff[axis_sel[1:0]] : dp2_ff[axis_sel[1:0]];
         mac_b = sel_in ? du2_ff : du1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc && phase_ff == 2'd0) begin
         hp_ff[0] <= req_chan.pos_x;
         hp_ff[1] <= req_chan.pos_y;
         hp_ff[2] <= req_chan.pos_z;
         ht_ff[0] <= req_chan.tex_u;
         ht_ff[1] <= req_chan.tex_v;
      end
      if (req_acc && phase_ff == 2'd1) begin
         hp_ff[3] <= req_chan.pos_x;
         hp_ff[4] <= req_chan.pos_y;
         hp_ff[5] <= req_chan.pos_z;
         ht_ff[2] <= req_chan.tex_u;
         ht_ff[3] <= req_chan.tex_v;
      end
      if (req_acc && phase_ff == LAST_PHASE) begin
         for (int k = 0; k < 3; k++) begin
            dp1_ff[k] <= DW'($signed(hp_ff[3+k])) - DW'($signed(hp_ff[k]));
         end
         dp2_ff[0] <= DW'(req_chan.pos_x) - DW'($signed(hp_ff[0]));
         dp2_ff[1] <= DW'(req_chan.pos_y) - DW'($signed(hp_ff[1]));
         dp2_ff[2] <= DW'(req_chan.pos_z) - DW'($signed(hp_ff[2]));
         du1_ff    <= DW'($signed(ht_ff[2])) - DW'($signed(ht_ff[0]));
         dv1_ff    <= DW'($signed(ht_ff[3])) - DW'($signed(ht_ff[1]));
         du2_ff    <= DW'(req_chan.tex_u) - DW'($signed(ht_ff[0]));
         dv2_ff    <= DW'(req_chan.tex_v) - DW'($signed(ht_ff[1]));
      end
      if (det_we) begin
         det_ff <= mac_acc;
      end
      if (res_we) begin
         res_ff[comp_ff] <= div_quot;
      end
      if (out_load) begin
         for (int k = 0; k < 6; k++) begin
            out_ff[k] <= degen_ff ? 32'sd0 : res_ff[k];
         end
         out_degen_ff <= degen_ff;
      end
   end

   tbt_mac u_mac (
      .clock (clock),
      .reset (reset),
      .cmd   (mac_cmd),
      .op_a  (mac_a),
      .op_b  (mac_b),
      .done  (mac_done),
      .acc   (mac_acc)
   );

   tbt_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (mac_acc),
      .den   (det_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.tangent_x   = out_ff[0];
   assign rsp_chan.tangent_y   = out_ff[1];
   assign rsp_chan.tangent_z   = out_ff[2];
   assign rsp_chan.bitangent_x = out_ff[3];
   assign rsp_chan.bitangent_y = out_ff[4];
   assign rsp_chan.bitangent_z = out_ff[5];
   assign rsp_chan.degenerate  = out_degen_ff;

   `TBT_ASSERT_IMP(a_degen_zero, clock, reset, rsp_chan.valid && rsp_chan.degenerate, rsp_chan.tangent_x == 0 && rsp_chan.bitangent_z == 0)
   `TBT_ASSERT_NXT(a_third_kicks, clock, reset, req_acc && phase_ff == LAST_PHASE, state_ff == S_KICK)
   `TBT_ASSERT_IMP(a_phase_range, clock, reset, 1'b1, phase_ff != 2'd3)
   `TBT_ASSERT_IMP(a_mac_done_busy, clock, reset, mac_done, state_ff == S_DMUL || state_ff == S_NMUL)
endmodule
